@@ rtl/tffc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tffc_pkg
// Types, constants and the color ramp shared by the thermal frame
// false-color writer, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package tffc_pkg;

  // Field widths.
  localparam int BYTE_W     = 8;
  localparam int OFFSET_W   = 32;
  localparam int STRIDE_W   = 14;
  localparam int ORG_W      = 12;
  localparam int COLD_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CHAN_W     = 4;

  // Register reset values.
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 14'd7680;
  localparam logic [ORG_W-1:0]    ORG_X_RST  = 12'd450;
  localparam logic [ORG_W-1:0]    ORG_Y_RST  = 12'd250;
  localparam logic [COLD_W-1:0]   COLD_RST   = 16'd2800;

  // Frame header, first byte first.
  localparam logic [BYTE_W-1:0] HEADER [4] = '{8'h5A, 8'h5A, 8'h02, 8'h06};

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_LINE_STRIDE = 2'd0,
    CFG_ORIGIN_X    = 2'd1,
    CFG_ORIGIN_Y    = 2'd2,
    CFG_COLD_LIMIT  = 2'd3
  } cfg_reg_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_COLOR,
    SEQ_BASE,
    SEQ_EMIT
  } seq_state_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // Five-band ramp: blue, cyan, green, yellow, red. Bands are 160 counts
  // wide above the cold limit and levels step every 10 counts. The
  // quotient by 10 is taken by a reciprocal multiply, exact below 160.
  function automatic rgb_t map_color(logic [COLD_W-1:0] value,
                                     logic [COLD_W-1:0] cold);
    logic [COLD_W-1:0] d;
    logic [7:0]        e;
    logic [15:0]       prod;
    logic [3:0]        q;
    rgb_t              c;
    d       = value - cold;
    c.red   = 4'd0;
    c.green = 4'd0;
    c.blue  = 4'd15;
    priority if (d < 16'd160) begin
      e = d[7:0];
    end else if (d < 16'd320) begin
      e = 8'(d - 16'd160);
    end else if (d < 16'd480) begin
      e = 8'(d - 16'd320);
    end else if (d < 16'd640) begin
      e = 8'(d - 16'd480);
    end else begin
      e = 8'd0;
    end
    prod = 16'(e) * 16'd205;
    q    = prod[14:11];
    if (value > cold) begin
      // A level of "quotient minus one" is clamped at zero at band starts.
      priority if (d < 16'd160) begin
        c.green = (q == 4'd0) ? 4'd0 : q - 4'd1;
      end else if (d < 16'd320) begin
        c.green = 4'd15;
        c.blue  = 4'd15 - q;
      end else if (d < 16'd480) begin
        c.green = 4'd15;
        c.blue  = 4'd0;
        c.red   = (q == 4'd0) ? 4'd0 : q - 4'd1;
      end else if (d < 16'd640) begin
        c.red   = 4'd15;
        c.blue  = 4'd0;
        c.green = 4'd15 - q;
      end else begin
        c.red   = 4'd15;
        c.blue  = 4'd0;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/tffc_rx_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tffc_rx_if
// Byte stream channel into the writer: valid, ready and one received byte.
// ----------------------------------------------------------------------------
interface tffc_rx_if;
  logic                          valid;
  logic                          ready;
  logic [tffc_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/tffc_px_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tffc_px_if
// Line run channel out of the writer: frame offset, pixel bytes and flags.
// ----------------------------------------------------------------------------
interface tffc_px_if;
  logic                          valid;
  logic                          ready;
  logic [tffc_pkg::OFFSET_W-1:0] write_offset;
  logic [tffc_pkg::BYTE_W-1:0]   green_byte;
  logic [tffc_pkg::BYTE_W-1:0]   red_blue_byte;
  logic                          run_last;
  logic                          frame_last;

  modport source (output valid, output write_offset, output green_byte,
                  output red_blue_byte, output run_last, output frame_last,
                  input ready);
  modport sink   (input valid, input write_offset, input green_byte,
                  input red_blue_byte, input run_last, input frame_last,
                  output ready);
endinterface

@@ rtl/thermal_frame_false_color_writer_core.sv @@
`timescale 1ns / 1ps
// Header bytes and low temperature bytes are taken without leaving the idle state.
// A high temperature byte passes through the color ramp and row multiply step,
// then the base add, then one line run per cycle from the shared offset adder
// while the sink is ready. The first line run is offered once the sequencer
// has passed the color and base states after the high byte is accepted.
// Reset (asynchronous, active low) restores register defaults and hunts the header.
// ----------------------------------------------------------------------------
// thermal_frame_false_color_writer_core
// Receives framed 16-bit temperatures, maps them to a color ramp and emits
// one frame write per line of each enlarged pixel square.
// ----------------------------------------------------------------------------
module thermal_frame_false_color_writer_core #(
  parameter int EXPAND_FACTOR = 13,
  parameter int MAP_COLUMNS   = 32,
  parameter int MAP_ROWS      = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  tffc_pkg::cfg_reg_e                cfg_idx_i,
  input  logic [tffc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  tffc_rx_if.sink                           rx_i,
  tffc_px_if.source                         px_o
);
  import tffc_pkg::*;

  localparam int ColW      = (MAP_COLUMNS > 1) ? $clog2(MAP_COLUMNS) : 1;
  localparam int RowW      = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int LineW     = (EXPAND_FACTOR > 1) ? $clog2(EXPAND_FACTOR) : 1;
  localparam int ExpW      = $clog2(EXPAND_FACTOR + 1);
  localparam int RowSpanW  = ExpW + RowW;
  localparam int TermW     = ((RowSpanW > ORG_W) ? RowSpanW : ORG_W) + 1;
  localparam int ProdW     = STRIDE_W + TermW;
  localparam int ColSpanW  = ExpW + 2 + ColW;

  // Configuration registers.
  logic [STRIDE_W-1:0] stride_q;
  logic [ORG_W-1:0]    origin_x_q;
  logic [ORG_W-1:0]    origin_y_q;
  logic [COLD_W-1:0]   cold_q;

  // Receive state.
  logic [1:0]          hdr_prog_q;
  logic                receiving_q;
  logic                phase_q;
  logic [BYTE_W-1:0]   low_byte_q;
  logic [ColW-1:0]     col_q;
  logic [RowW-1:0]     row_q;

  // Datapath registers.
  logic [COLD_W-1:0]   value_q;
  rgb_t                rgb_q;
  logic [ProdW-1:0]    prod_q;
  logic [OFFSET_W-1:0] acc_q;
  logic [LineW-1:0]    line_q;
  logic                last_pix_q;

  seq_state_e          state_q, state_d;

  logic                in_acc;
  logic                out_acc;
  logic                line_end;
  logic                col_end;
  logic                row_end;
  logic [RowSpanW-1:0] row_span;
  logic [TermW-1:0]    row_term;
  logic [ColSpanW-1:0] col_term;
  logic [OFFSET_W-1:0] adder_a;
  logic [OFFSET_W-1:0] adder_b;
  logic [OFFSET_W-1:0] adder_sum;

  assign in_acc   = rx_i.valid && rx_i.ready;
  assign out_acc  = px_o.valid && px_o.ready;
  assign line_end = (line_q == LineW'(EXPAND_FACTOR - 1));
  assign col_end  = (col_q == ColW'(MAP_COLUMNS - 1));
  assign row_end  = (row_q == RowW'(MAP_ROWS - 1));

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q   <= STRIDE_RST;
      origin_x_q <= ORG_X_RST;
      origin_y_q <= ORG_Y_RST;
      cold_q     <= COLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LINE_STRIDE: stride_q   <= cfg_data_i[STRIDE_W-1:0];
        CFG_ORIGIN_X:    origin_x_q <= cfg_data_i[ORG_W-1:0];
        CFG_ORIGIN_Y:    origin_y_q <= cfg_data_i[ORG_W-1:0];
        CFG_COLD_LIMIT:  cold_q     <= cfg_data_i[COLD_W-1:0];
        default:         ;
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: only the high byte of a pixel leaves the idle state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (in_acc && receiving_q && phase_q) begin
          state_d = SEQ_COLOR;
        end
      end
      SEQ_COLOR: state_d = SEQ_BASE;
      SEQ_BASE:  state_d = SEQ_EMIT;
      SEQ_EMIT: begin
        if (out_acc && line_end) begin
          state_d = SEQ_IDLE;
        end
      end
      default:   state_d = SEQ_IDLE;
    endcase
  end

  // Row and column terms of the pixel's frame offset.
  assign row_span = RowSpanW'(EXPAND_FACTOR) * RowSpanW'(row_q);
  assign row_term = TermW'(origin_y_q) + TermW'(row_span);
  assign col_term = ColSpanW'(4 * EXPAND_FACTOR) * ColSpanW'(col_q);

  // Shared offset adder: base sum in the base step, one stride per line after.
  always_comb begin
    if (state_q == SEQ_BASE) begin
      adder_a = OFFSET_W'(prod_q);
      adder_b = OFFSET_W'({origin_x_q, 2'b00}) + OFFSET_W'(col_term);
    end else begin
      adder_a = acc_q;
      adder_b = OFFSET_W'(stride_q);
    end
    adder_sum = adder_a + adder_b;
  end

  // Header hunt, byte pairing and pixel counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_prog_q  <= 2'd0;
      receiving_q <= 1'b0;
      phase_q     <= 1'b0;
      low_byte_q  <= '0;
      col_q       <= '0;
      row_q       <= '0;
    end else if (in_acc) begin
      if (!receiving_q) begin
        if (rx_i.rx_byte == HEADER[hdr_prog_q]) begin
          if (hdr_prog_q == 2'd3) begin
            hdr_prog_q  <= 2'd0;
            receiving_q <= 1'b1;
            phase_q     <= 1'b0;
            col_q       <= '0;
            row_q       <= '0;
          end else begin
            hdr_prog_q <= hdr_prog_q + 2'd1;
          end
        end else begin
          hdr_prog_q <= 2'd0;
        end
      end else if (!phase_q) begin
        low_byte_q <= rx_i.rx_byte;
        phase_q    <= 1'b1;
      end else begin
        phase_q <= 1'b0;
      end
    end else if (out_acc && line_end) begin
      // Advance to the next pixel once its last line run is taken.
      if (last_pix_q) begin
        receiving_q <= 1'b0;
        col_q       <= '0;
        row_q       <= '0;
      end else if (col_end) begin
        col_q <= '0;
        row_q <= row_q + RowW'(1);
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

  // Pixel datapath.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      SEQ_IDLE: begin
        value_q <= {rx_i.rx_byte, low_byte_q};
      end
      SEQ_COLOR: begin
        rgb_q  <= map_color(value_q, cold_q);
        prod_q <= ProdW'(stride_q) * ProdW'(row_term);
      end
      SEQ_BASE: begin
        acc_q      <= adder_sum;
        line_q     <= '0;
        last_pix_q <= row_end && col_end;
      end
      SEQ_EMIT: begin
        if (out_acc) begin
          acc_q  <= adder_sum;
          line_q <= line_q + LineW'(1);
        end
      end
      default: ;
    endcase
  end

  // Channel outputs.
  assign rx_i.ready         = (state_q == SEQ_IDLE);
  assign px_o.valid         = (state_q == SEQ_EMIT);
  assign px_o.write_offset  = acc_q;
  assign px_o.green_byte    = {rgb_q.green, 4'd0};
  assign px_o.red_blue_byte = {rgb_q.blue, rgb_q.red};
  assign px_o.run_last      = line_end;
  assign px_o.frame_last    = last_pix_q;

endmodule

@@ rtl/tffc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tffc_checker
// Port-level checks of the writer's channel sequencing over time.
// ----------------------------------------------------------------------------
module tffc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [tffc_pkg::OFFSET_W-1:0] out_offset_i,
  input logic                          out_run_last_i,
  input logic                          out_frame_last_i
);
  import tffc_pkg::*;

  logic out_acc;
  assign out_acc = out_valid_i && out_ready_i;

  // The block never takes a byte while a line run is pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> !out_valid_i)
    else $error("input ready while a line run is pending");

  // After the last line run of a pixel the output goes quiet.
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_run_last_i) |=> (!out_valid_i && in_ready_i))
    else $error("output still busy after the last line run");

  // A pixel's line runs follow each other without a gap and share frame_last.
  a_run_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !out_run_last_i) |=> (out_valid_i && $stable(out_frame_last_i)))
    else $error("line runs of one pixel broke off");

  // A stalled line run holds its offset.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_offset_i)))
    else $error("stalled line run changed");

endmodule

bind thermal_frame_false_color_writer_core tffc_checker u_tffc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (rx_i.valid),
  .in_ready_i       (rx_i.ready),
  .out_valid_i      (px_o.valid),
  .out_ready_i      (px_o.ready),
  .out_offset_i     (px_o.write_offset),
  .out_run_last_i   (px_o.run_last),
  .out_frame_last_i (px_o.frame_last)
);
